FILE: rtl/tlv_stream_deframer_core_assert.svh
// Assertion macros for the TLV stream deframer checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef TLV_STREAM_DEFRAMER_CORE_ASSERT_SVH
`define TLV_STREAM_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tsd_pkg.sv
// Shared types and constants of the TLV stream deframer.
// No dependencies; imported by the parser, the output buffer and the top level.
package tsd_pkg;

	localparam int unsigned HdrBytes = 6;
	localparam logic [2:0] HDR_LAST_IDX = 3'(HdrBytes - 1);
	localparam logic [2:0] VALUE_PHASE = 3'(HdrBytes);
	localparam logic [2:0] TYPE_BYTES = 3'd2;

	localparam int unsigned PaddrW = 3;
	localparam logic REG_IDX_LITTLE_ENDIAN = 1'b0;

	typedef struct packed {
		logic [15:0] msg_type;
		logic [31:0] msg_length;
		logic        has_value;
		logic [7:0]  value_byte;
		logic        last_of_message;
	} tsd_result_t;

	typedef struct packed {
		logic        push;
		tsd_result_t result;
	} tsd_push_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

FILE: rtl/tsd_parser.sv
// Header and value-phase parser of the TLV stream deframer.
// Depends on tsd_pkg; feeds at most one result per accepted byte to the output buffer.
module tsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              little_endian,
	output tsd_pkg::tsd_push_t push_o
);
	import tsd_pkg::*;

	logic [2:0]  hdr_cnt_q;
	logic [15:0] type_q;
	logic [31:0] len_q;
	logic [31:0] remain_q;

	logic [2:0]  hdr_cnt_d;
	logic [15:0] type_d;
	logic [31:0] len_d;
	logic [31:0] remain_d;
	logic [15:0] type_base;
	logic [31:0] len_base;
	logic [15:0] type_sh;
	logic [31:0] len_sh;
	logic        last_val;
	logic [2:0]  cnt_eff;

	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		type_d = type_q;
		len_d = len_q;
		remain_d = remain_q;
		push_o = '0;
		last_val = (remain_q <= 32'd1);
		cnt_eff = (hdr_cnt_q > HDR_LAST_IDX) ? 3'd0 : hdr_cnt_q;
		type_base = (cnt_eff == 3'd0) ? 16'd0 : type_q;
		len_base = (cnt_eff == 3'd0) ? 32'd0 : len_q;
		type_sh = type_base;
		len_sh = len_base;
		if (cnt_eff < TYPE_BYTES) begin
			type_sh = {type_base[7:0], in_byte};
		end else begin
			len_sh = {len_base[23:0], in_byte};
		end

		if (accept) begin
			if (hdr_cnt_q == VALUE_PHASE) begin
				push_o.push = 1'b1;
				push_o.result = '{msg_type: type_q, msg_length: len_q, has_value: 1'b1,
					value_byte: in_byte, last_of_message: last_val};
				if (last_val) begin
					remain_d = 32'd0;
					hdr_cnt_d = 3'd0;
				end else begin
					remain_d = remain_q - 32'd1;
				end
			end else if (cnt_eff == HDR_LAST_IDX) begin
				type_d = little_endian ? swap16(type_sh) : type_sh;
				len_d = little_endian ? swap32(len_sh) : len_sh;
				if (len_sh == 32'd0) begin
					// Empty message: one marker result, then back to header reception.
					push_o.push = 1'b1;
					push_o.result = '{msg_type: type_d, msg_length: 32'd0, has_value: 1'b0,
						value_byte: 8'd0, last_of_message: 1'b1};
					hdr_cnt_d = 3'd0;
					remain_d = 32'd0;
				end else begin
					remain_d = len_d;
					hdr_cnt_d = VALUE_PHASE;
				end
			end else begin
				type_d = type_sh;
				len_d = len_sh;
				hdr_cnt_d = cnt_eff + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= 3'd0;
			type_q <= 16'd0;
			len_q <= 32'd0;
			remain_q <= 32'd0;
		end else begin
			hdr_cnt_q <= hdr_cnt_d;
			type_q <= type_d;
			len_q <= len_d;
			remain_q <= remain_d;
		end
	end

endmodule

FILE: rtl/tsd_out_buf.sv
// Result register with one skid entry for the TLV stream deframer.
// Depends on tsd_pkg; decouples input acceptance from output stalls.
module tsd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsd_pkg::tsd_push_t   push_i,
	output logic                 full,
	output logic                 res_valid,
	input  logic                 res_stall,
	output tsd_pkg::tsd_result_t res_o
);
	import tsd_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	tsd_result_t out_q;
	tsd_result_t skid_q;
	logic        out_fire;

	assign out_fire = out_valid_q && !res_stall;
	assign full = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res_o = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push_i.push) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (push_i.push) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= push_i.result;
			end else begin
				out_q <= push_i.result;
			end
		end
	end

endmodule

FILE: rtl/tlv_stream_deframer_core.sv
// Top level of the TLV stream deframer: configuration register and channel ports.
// Depends on tsd_pkg, tsd_parser and tsd_out_buf.
//
// Channel   Direction  Handshake             Payload
// byte      in         byte_valid/byte_stall in_byte
// result    out        res_valid/res_stall   msg_type, msg_length, has_value,
//                                            value_byte, last_of_message
// config    in         APB psel/penable      paddr, pwdata, prdata
//
// One byte is accepted per cycle while byte_stall is low. A byte's result, if any,
// is registered in the result register, or in the skid entry while that register
// holds a stalled result, so the next byte is still accepted; byte_stall rises only
// when both entries hold results.
// Reset clears the parser to header reception and empties both result entries;
// little_endian resets to big-endian order.
module tlv_stream_deframer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  logic [7:0]                 in_byte,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [15:0]                msg_type,
	output logic [31:0]                msg_length,
	output logic                       has_value,
	output logic [7:0]                 value_byte,
	output logic                       last_of_message,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tsd_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import tsd_pkg::*;

	logic        little_endian_q;
	logic        accept;
	logic        buf_full;
	tsd_push_t   push;
	tsd_result_t res;

	// The register index is the word address; byte offsets within a word are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[PaddrW-1] == REG_IDX_LITTLE_ENDIAN) ?
		{31'd0, little_endian_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr[PaddrW-1] == REG_IDX_LITTLE_ENDIAN) begin
			little_endian_q <= pwdata[0];
		end
	end

	// A byte transaction completes whenever the result buffer has room.
	assign byte_stall = buf_full;
	assign accept = byte_valid && !byte_stall;

	tsd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.little_endian(little_endian_q),
		.push_o       (push)
	);

	tsd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_i   (push),
		.full     (buf_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_o    (res)
	);

	assign msg_type = res.msg_type;
	assign msg_length = res.msg_length;
	assign has_value = res.has_value;
	assign value_byte = res.value_byte;
	assign last_of_message = res.last_of_message;

endmodule

FILE: rtl/tsd_checker.sv
// Port-level assertion checker for the TLV stream deframer, with its bind.
// Depends on tlv_stream_deframer_core_assert.svh and the top level's ports.
`include "tlv_stream_deframer_core_assert.svh"

module tsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [31:0] msg_length,
	input logic        has_value,
	input logic [7:0]  value_byte,
	input logic        last_of_message
);

	`TSD_ASSERT_NEXT(a_res_valid_holds, res_valid && res_stall, res_valid, "result valid dropped while stalled")
	`TSD_ASSERT_NOW(a_empty_marker, res_valid && !has_value, value_byte == 8'd0 && last_of_message && msg_length == 32'd0, "malformed empty message marker")
	`TSD_ASSERT_NOW(a_not_last_len, res_valid && has_value && !last_of_message, msg_length > 32'd1, "non-final value byte in a message shorter than two bytes")
	`TSD_ASSERT_NEXT(a_last_after_one, res_valid && !res_stall && has_value && msg_length == 32'd1, 1'b1 && !(res_valid && has_value && !last_of_message && msg_length == 32'd1), "length-one message without last mark")

endmodule

bind tlv_stream_deframer_core tsd_checker u_tsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.msg_length     (msg_length),
	.has_value      (has_value),
	.value_byte     (value_byte),
	.last_of_message(last_of_message)
);
